FILE: rtl/core/spq_pkg.sv
`default_nettype none
package spq_pkg;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELMAX = 3'd1;
  localparam logic [2:0] OP_DELMIN = 3'd2;
  localparam logic [2:0] OP_DELAT  = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
    logic [3:0]         position;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [4:0]         entry_count;
    logic [1:0]         status;
  } rsp_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic               insert;
    logic               remove;
    logic signed [31:0] value;
  } cell_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/spq_stream_if.sv
`default_nettype none
interface spq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/spq_cell.sv
`default_nettype none
module spq_cell #(
  parameter int Index = 0,
  parameter int CntW  = 5
) (
  input  wire logic                clk,
  input  wire spq_pkg::cell_cmd_t  cmd,
  input  wire logic [CntW-1:0]     count,
  input  wire logic [CntW-1:0]     rm_pos,
  input  wire logic                left_place,
  input  wire logic signed [31:0]  left_entry,
  input  wire logic signed [31:0]  right_entry,
  output logic                     place,
  output logic signed [31:0]       entry
);

  logic below_count;
  logic at_count;

  // A new value lands after every entry that is greater than or equal to it,
  // so place is high from the insertion point up to the current count.
  assign below_count = CntW'(Index) < count;
  assign at_count    = CntW'(Index) == count;
  assign place       = (below_count && (entry < cmd.value)) || at_count;

  always_ff @(posedge clk) begin
    if (cmd.insert && place) begin
      entry <= left_place ? left_entry : cmd.value;
    end else if (cmd.remove && (CntW'(Index) >= rm_pos)) begin
      entry <= right_entry;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sorted_priority_queue_core.sv
`default_nettype none
// A result is registered and appears in the cycle after its request item is accepted.
// Throughput: one item per cycle while results are taken; all cells of the chain
// shift together, and a result that waits holds off the input side.
// Reset: rst is synchronous and active high; it empties the queue and drops any
// pending result. Stored entries are not cleared.
module sorted_priority_queue_core #(
  parameter int DEPTH = 16
) (
  input wire logic clk,
  input wire logic rst,
  spq_stream_if.sink   req,
  spq_stream_if.source rsp
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CmpW = (CntW > 4) ? CntW : 4;

  logic [CntW-1:0]    count;
  logic [CntW-1:0]    count_next;
  logic               rsp_valid;
  spq_pkg::rsp_t      rsp_data;
  spq_pkg::rsp_t      rsp_next;
  spq_pkg::cell_cmd_t cmd;
  logic               acc;
  logic               do_insert;
  logic               do_remove;
  logic [CmpW-1:0]    sel_pos;
  logic [CntW-1:0]    rm_pos;
  logic [AW-1:0]      rd_idx;
  logic signed [31:0] entry_q [DEPTH];
  logic               place_q [DEPTH];

  assign req.ready = !rsp_valid || rsp.ready;
  assign acc       = req.valid && req.ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  assign rm_pos = sel_pos[CntW-1:0];
  assign rd_idx = sel_pos[AW-1:0];

  always_comb begin
    do_insert  = 1'b0;
    do_remove  = 1'b0;
    count_next = count;
    sel_pos    = CmpW'(req.data.position);
    rsp_next.result_value = '0;
    rsp_next.status       = spq_pkg::ST_OK;
    case (req.data.operation)
      spq_pkg::OP_INSERT: begin
        if (count == CntW'(DEPTH)) begin
          rsp_next.status = spq_pkg::ST_FULL;
        end else begin
          do_insert  = 1'b1;
          count_next = count + 1'b1;
          rsp_next.result_value = req.data.value;
        end
      end
      spq_pkg::OP_DELMAX, spq_pkg::OP_DELMIN, spq_pkg::OP_DELAT,
      spq_pkg::OP_READ: begin
        if (req.data.operation == spq_pkg::OP_DELMAX) begin
          sel_pos = '0;
        end else if (req.data.operation == spq_pkg::OP_DELMIN) begin
          sel_pos = CmpW'(count - 1'b1);
        end
        if (count == '0) begin
          rsp_next.status = spq_pkg::ST_EMPTY;
        end else if (sel_pos >= CmpW'(count) || sel_pos >= CmpW'(DEPTH)) begin
          rsp_next.status = spq_pkg::ST_BADPOS;
        end else begin
          rsp_next.result_value = entry_q[rd_idx];
          if (req.data.operation != spq_pkg::OP_READ) begin
            do_remove  = 1'b1;
            count_next = count - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    rsp_next.entry_count = 5'(count_next);
  end

  assign cmd.insert = acc && do_insert;
  assign cmd.remove = acc && do_remove;
  assign cmd.value  = req.data.value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               left_place;
    logic signed [31:0] left_entry;
    logic signed [31:0] right_entry;

    if (i == 0) begin : g_first
      assign left_place = 1'b0;
      assign left_entry = '0;
    end else begin : g_mid
      assign left_place = place_q[i-1];
      assign left_entry = entry_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_entry = entry_q[i];
    end else begin : g_inner
      assign right_entry = entry_q[i+1];
    end

    spq_cell #(
      .Index (i),
      .CntW  (CntW)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .count       (count),
      .rm_pos      (rm_pos),
      .left_place  (left_place),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .place       (place_q[i]),
      .entry       (entry_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (acc) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp_data <= rsp_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("queue count exceeds its depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !acc |=> $stable(count))
    else $error("queue count changed without an accepted item");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    acc |=> rsp_valid)
    else $error("accepted item produced no result");

  a_no_move_on_error: assert property (@(posedge clk) disable iff (rst)
    acc && rsp_next.status != spq_pkg::ST_OK |-> !cmd.insert && !cmd.remove)
    else $error("cells shifted on a rejected item");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    acc && rsp_next.status == spq_pkg::ST_FULL |=> count == CntW'(DEPTH))
    else $error("full status reported while the queue was not full");

endmodule
`default_nettype wire

FILE: tb/sorted_priority_queue_core_tb.sv
`timescale 1ns / 1ps
module sorted_priority_queue_core_tb;

  localparam int DEPTH = 16;
  localparam int MAX_GAP = 14;
  localparam int ITEM_TARGET = 1100;
  localparam logic [2:0] OP_SPARE_LO  = 3'd5;
  localparam logic [2:0] OP_SPARE_MID = 3'd6;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} phase_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  spq_stream_if #(.payload_t(spq_pkg::req_t)) req_ch ();
  spq_stream_if #(.payload_t(spq_pkg::rsp_t)) rsp_ch ();

  sorted_priority_queue_core #(
    .DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mirror of the sorted store plus the replies still owed by the block.
  class sorted_queue_mirror;
    logic signed [31:0] held[$];
    spq_pkg::rsp_t awaited[$];
    int unsigned faults = 0;

    function void fault(string msg);
      faults++;
      if (faults <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void note_request(spq_pkg::req_t r);
      spq_pkg::rsp_t e;
      int k;
      int pos;
      e.result_value = '0;
      e.status = spq_pkg::ST_OK;
      case (r.operation)
        spq_pkg::OP_INSERT: begin
          if (held.size() >= DEPTH) begin
            e.status = spq_pkg::ST_FULL;
          end else begin
            // A new value goes behind every entry that is greater or equal.
            k = held.size();
            while (k > 0 && held[k-1] < r.value) k--;
            held.insert(k, r.value);
            e.result_value = r.value;
          end
        end
        spq_pkg::OP_DELMAX, spq_pkg::OP_DELMIN, spq_pkg::OP_DELAT, spq_pkg::OP_READ: begin
          if (held.size() == 0) begin
            e.status = spq_pkg::ST_EMPTY;
          end else begin
            if (r.operation == spq_pkg::OP_DELMAX) pos = 0;
            else if (r.operation == spq_pkg::OP_DELMIN) pos = held.size() - 1;
            else pos = r.position;
            if (pos >= held.size()) begin
              e.status = spq_pkg::ST_BADPOS;
            end else begin
              e.result_value = held[pos];
              if (r.operation != spq_pkg::OP_READ) held.delete(pos);
            end
          end
        end
        default: ;
      endcase
      e.entry_count = 5'(held.size());
      awaited.insert(awaited.size(), e);
    endfunction

    function void check_result(spq_pkg::rsp_t got);
      spq_pkg::rsp_t e;
      if (awaited.size() == 0) begin
        fault($sformatf("result with nothing expected: value=%0d count=%0d status=%0d",
                        got.result_value, got.entry_count, got.status));
        return;
      end
      e = awaited.pop_front();
      if (got.result_value !== e.result_value || got.entry_count !== e.entry_count ||
          got.status !== e.status)
        fault($sformatf({"mismatch: expected value=%0d count=%0d status=%0d, ",
                         "got value=%0d count=%0d status=%0d"},
                        e.result_value, e.entry_count, e.status,
                        got.result_value, got.entry_count, got.status));
    endfunction
  endclass

  sorted_queue_mirror mirror = new();
  bit req_calm = 1'b0;
  bit rsp_calm = 1'b0;
  int real_items = 0;

  task automatic send_request(spq_pkg::req_t r);
    int gap;
    gap = req_calm ? 0 : $urandom_range(0, MAX_GAP);
    repeat (gap) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk); while (!req_ch.ready);
    mirror.note_request(r);
    if (r.operation <= spq_pkg::OP_READ) real_items++;
  endtask

  task automatic send(logic [2:0] op, logic signed [31:0] value, logic [3:0] pos);
    spq_pkg::req_t r;
    r.operation = op;
    r.value = value;
    r.position = pos;
    send_request(r);
  endtask

  function automatic logic signed [31:0] pick_value();
    int roll;
    int n;
    roll = $urandom_range(0, 99);
    n = mirror.held.size();
    if (roll < 45) return $urandom;
    if (roll < 75) return int'($urandom_range(0, 8)) - 4;
    if (roll < 85) return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
    // Values next to stored entries stress the tie ordering.
    if (n > 0) return mirror.held[$urandom_range(0, n - 1)] + (int'($urandom_range(0, 2)) - 1);
    return $urandom;
  endfunction

  function automatic spq_pkg::req_t random_request(phase_mode_t mode);
    spq_pkg::req_t r;
    int roll;
    int ins_cut;
    int read_cut;
    int n;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin ins_cut = 80; read_cut = 86; end
      MODE_DRAIN: begin ins_cut = 12; read_cut = 22; end
      default: begin ins_cut = 42; read_cut = 58; end
    endcase
    if (roll < ins_cut) r.operation = spq_pkg::OP_INSERT;
    else if (roll < read_cut) r.operation = spq_pkg::OP_READ;
    else if (roll < 97) begin
      case ($urandom_range(0, 2))
        0: r.operation = spq_pkg::OP_DELMAX;
        1: r.operation = spq_pkg::OP_DELMIN;
        default: r.operation = spq_pkg::OP_DELAT;
      endcase
    end else r.operation = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    r.value = pick_value();
    n = mirror.held.size();
    if (n > 0 && $urandom_range(0, 99) < 80) r.position = 4'($urandom_range(0, n - 1));
    else r.position = 4'($urandom_range(0, 15));
    return r;
  endfunction

  // Result side: a fresh stall before every item, none during calm phases.
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = rsp_calm ? 0 : $urandom_range(0, MAX_GAP);
      repeat (stall) begin
        @(negedge clk);
        rsp_ch.ready <= 1'b0;
      end
      @(negedge clk);
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      mirror.check_result(rsp_ch.data);
    end
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    phase_mode_t mode;
    int phase_len;
    int waited;
    int first_phase;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reads and deletes on an empty queue are refused, whatever the position.
    send(spq_pkg::OP_READ, 32'sd0, 4'd15);
    send(spq_pkg::OP_DELMAX, 32'sd0, 4'd0);
    send(spq_pkg::OP_DELMIN, 32'sd0, 4'd0);
    send(spq_pkg::OP_DELAT, 32'sd0, 4'd0);
    send(OP_SPARE_LO, 32'sd7, 4'd0);
    send(OP_SPARE_MID, 32'sd7, 4'd0);
    send(OP_SPARE_HI, -32'sd1, 4'd15);
    send(spq_pkg::OP_INSERT, 32'sh7FFFFFFF, 4'd0);
    send(spq_pkg::OP_INSERT, 32'sh80000000, 4'd0);
    send(spq_pkg::OP_INSERT, 32'sd0, 4'd0);
    send(spq_pkg::OP_INSERT, -32'sd1, 4'd0);
    send(spq_pkg::OP_INSERT, -32'sd1, 4'd0);
    send(spq_pkg::OP_INSERT, 32'sd5, 4'd0);
    send(spq_pkg::OP_READ, 32'sd0, 4'd0);
    send(spq_pkg::OP_READ, 32'sd0, 4'd5);
    send(spq_pkg::OP_READ, 32'sd0, 4'd6);
    send(spq_pkg::OP_READ, 32'sd0, 4'd15);
    send(spq_pkg::OP_DELAT, 32'sd0, 4'd15);
    send(spq_pkg::OP_DELAT, 32'sd0, 4'd2);
    send(spq_pkg::OP_DELMAX, 32'sd0, 4'd0);
    send(spq_pkg::OP_DELMIN, 32'sd0, 4'd0);

    // Phases are picked at random among filling, draining and a mix, starting with a fill.
    first_phase = 1;
    while (real_items < ITEM_TARGET) begin
      if (first_phase) begin
        mode = MODE_FILL;
        phase_len = 40;
        first_phase = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: mode = MODE_FILL;
          1: mode = MODE_DRAIN;
          default: mode = MODE_MIX;
        endcase
        phase_len = $urandom_range(10, 60);
      end
      req_calm = ($urandom_range(0, 3) == 0);
      rsp_calm = ($urandom_range(0, 3) == 0);
      repeat (phase_len) send_request(random_request(mode));
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;
    waited = 0;
    while (mirror.awaited.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (mirror.awaited.size() != 0)
      mirror.fault($sformatf("%0d results never arrived", mirror.awaited.size()));

    if (mirror.faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/spq_pkg.sv
rtl/core/spq_stream_if.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_core.sv
tb/sorted_priority_queue_core_tb.sv
